/* rtl/window_sender_with_retx_timer_core_macros.svh */
// assertion macros shared by the window sender rtl
// no dependencies; expects clk and rst_n in the scope of use
`ifndef WINDOW_SENDER_WITH_RETX_TIMER_CORE_MACROS_SVH
`define WINDOW_SENDER_WITH_RETX_TIMER_CORE_MACROS_SVH

// property checked every cycle outside reset
`define WSRT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// trigger implies consequence in the next cycle, outside reset
`define WSRT_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) else $error(msg);

`endif

/* rtl/wsrt_pkg.sv */
// shared types, codes and constants of the window sender
// no dependencies
package wsrt_pkg;

  localparam int MAX_WINDOW_DEF = 32;

  localparam int SEQ_W      = 32;
  localparam int SEGB_W     = 14;
  localparam int HDR_W      = 8;
  localparam int WIN_W      = 6;
  localparam int SACK_CNT_W = 6;
  localparam int LEN_W      = 14;
  localparam int KIND_W     = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int SACKED_W   = SACK_CNT_W + SEGB_W;
  localparam int CNT_W      = 6;

  // input item kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACK   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  // result kinds
  localparam logic RES_SEG  = 1'b0;
  localparam logic RES_DONE = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_BYTES = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_BYTES  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOW_BYTES    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_WINDOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LIMIT  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_RETX_TICKS    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIORITY_MODE = 3'd6;

  // register reset values
  localparam logic [SEGB_W-1:0] RST_SEGMENT_BYTES = 14'd1460;
  localparam logic [HDR_W-1:0]  RST_HEADER_BYTES  = 8'd40;
  localparam logic [SEQ_W-1:0]  RST_FLOW_BYTES    = 32'd1460;
  localparam logic [WIN_W-1:0]  RST_START_WINDOW  = 6'd1;
  localparam logic [WIN_W-1:0]  RST_WINDOW_LIMIT  = 6'd32;
  localparam logic [SEQ_W-1:0]  RST_RETX_TICKS    = 32'd1000;

  // most segments released by one item
  localparam logic [CNT_W-1:0] SEG_CAP = 6'd63;
  localparam logic [LEN_W-1:0] LEN_MAX = 14'h3FFF;

  typedef struct packed {
    logic latch;
    logic clear;
    logic ack_upd;
    logic timeout;
    logic tick_dec;
    logic setup1;
    logic setup2;
    logic gen;
    logic emit_seg;
    logic rearm;
    logic emit_done;
  } cmd_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              flow_done;
    logic              armed;
    logic              left_le1;
    logic              new_ack;
    logic              cond;
    logic              stage_v;
    logic              done_pend;
    logic              out_free;
  } stat_t;

endpackage

/* rtl/window_sender_with_retx_timer_core.sv */
// top level of the window sender with retransmit timer
// depends on wsrt_pkg, wsrt_ctrl and wsrt_dp
//
// Sender side of one transport flow. Items on the in_ stream are start (tuser 0),
// ack (tuser 1) or tick (tuser 2); each produces zero or more results on the out_
// stream, the final one marked with tlast. A start item resets the flow and sends
// what the window allows; an ack records the sack bytes and, when it moves the
// oldest unacked byte, grows the window by one, sends more and restarts the timer;
// a tick counts the timer down and on expiry rewinds to the oldest unacked byte
// with a window of one. An ack covering the whole flow ends with a flow-done
// result. An item is taken only when the previous one is fully worked off (its
// results may still sit in the output register). A tick that only counts down,
// an ignored tick, a kind 3 item or an ack after the flow is done ends at
// dispatch, an ack that does not move the oldest unacked byte goes on to the
// post state; a start, a new ack or a timeout runs the send loop for n segments,
// n being at most 63, set by the check-then-generate loop around the send
// pointer adder; a flow-done result comes after the segments, and output stalls
// hold both. Configuration writes are always accepted and should only be made while
// no item is in flight.
module window_sender_with_retx_timer_core #(
  parameter int MAX_WINDOW = wsrt_pkg::MAX_WINDOW_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // ack_seq [31:0], sack_count [37:32], zero fill
  input  logic [1:0]  in_tuser,   // kind [1:0]

  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // segment_seq [31:0], segment_len [45:32],
                                  // priority_res [77:46], zero fill
  output logic [0:0]  out_tuser,  // result_kind [0]
  output logic        out_tlast,

  // register write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [wsrt_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [wsrt_pkg::CFG_DATA_W-1:0]   cfg_data
);

  wsrt_pkg::cmd_t  cmd;
  wsrt_pkg::stat_t stat;

  logic                         res_kind;
  logic [wsrt_pkg::SEQ_W-1:0]   res_seq;
  logic [wsrt_pkg::LEN_W-1:0]   res_len;
  logic [wsrt_pkg::SEQ_W-1:0]   res_prio;

  // sequencer: decodes the item kind and steps through the send run
  wsrt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // flow state, window arithmetic and the output register
  wsrt_dp #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .in_kind       (in_tuser),
    .in_ack_seq    (in_tdata[31:0]),
    .in_sack_count (in_tdata[37:32]),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_tvalid),
    .out_ready     (out_tready),
    .out_kind      (res_kind),
    .out_seq       (res_seq),
    .out_len       (res_len),
    .out_prio      (res_prio),
    .out_last      (out_tlast)
  );

  // pack the result fields, lowest field first
  assign out_tdata = {2'b00, res_prio, res_len, res_seq};
  assign out_tuser = res_kind;

endmodule

/* rtl/wsrt_ctrl.sv */
// sequencing state machine of the window sender
// depends on wsrt_pkg for command and status types
module wsrt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  wsrt_pkg::stat_t stat,
  output wsrt_pkg::cmd_t  cmd
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_SETUP1   = 3'd2;
  localparam logic [2:0] S_SETUP2   = 3'd3;
  localparam logic [2:0] S_CHECK    = 3'd4;
  localparam logic [2:0] S_GEN      = 3'd5;
  localparam logic [2:0] S_POST     = 3'd6;
  localparam logic [2:0] S_DONE     = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat.kind)
          wsrt_pkg::KIND_START: begin
            cmd.clear = 1'b1;
            state_nxt = S_SETUP1;
          end
          wsrt_pkg::KIND_ACK: begin
            if (stat.flow_done) begin
              state_nxt = S_IDLE;
            end else begin
              cmd.ack_upd = 1'b1;
              state_nxt   = stat.new_ack ? S_SETUP1 : S_POST;
            end
          end
          wsrt_pkg::KIND_TICK: begin
            if (!stat.armed) begin
              state_nxt = S_IDLE;
            end else if (stat.left_le1) begin
              cmd.timeout = 1'b1;
              state_nxt   = S_SETUP1;
            end else begin
              cmd.tick_dec = 1'b1;
              state_nxt    = S_IDLE;
            end
          end
          default: state_nxt = S_IDLE;
        endcase
      end
      S_SETUP1: begin
        cmd.setup1 = 1'b1;
        state_nxt  = S_SETUP2;
      end
      S_SETUP2: begin
        cmd.setup2 = 1'b1;
        state_nxt  = S_CHECK;
      end
      S_CHECK: begin
        // a staged segment leaves once the output register is free
        if (!stat.stage_v || stat.out_free) begin
          cmd.emit_seg = stat.stage_v;
          state_nxt    = stat.cond ? S_GEN : S_POST;
        end
      end
      S_GEN: begin
        cmd.gen   = 1'b1;
        state_nxt = S_CHECK;
      end
      S_POST: begin
        cmd.rearm = 1'b1;
        state_nxt = stat.done_pend ? S_DONE : S_IDLE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.emit_done = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/wsrt_dp.sv */
// datapath of the window sender: registers, flow state, window math, output register
// depends on wsrt_pkg and the assertion macro header
`include "window_sender_with_retx_timer_core_macros.svh"

module wsrt_dp #(
  parameter int MAX_WINDOW = wsrt_pkg::MAX_WINDOW_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  wsrt_pkg::cmd_t                   cmd,
  output wsrt_pkg::stat_t                  stat,
  input  logic [wsrt_pkg::KIND_W-1:0]      in_kind,
  input  logic [wsrt_pkg::SEQ_W-1:0]       in_ack_seq,
  input  logic [wsrt_pkg::SACK_CNT_W-1:0]  in_sack_count,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [wsrt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wsrt_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_kind,
  output logic [wsrt_pkg::SEQ_W-1:0]       out_seq,
  output logic [wsrt_pkg::LEN_W-1:0]       out_len,
  output logic [wsrt_pkg::SEQ_W-1:0]       out_prio,
  output logic                             out_last
);

  localparam int SEQ_W    = wsrt_pkg::SEQ_W;
  localparam int SEGB_W   = wsrt_pkg::SEGB_W;
  localparam int WIN_W    = wsrt_pkg::WIN_W;
  localparam int SACKED_W = wsrt_pkg::SACKED_W;
  localparam int CNT_W    = wsrt_pkg::CNT_W;
  localparam int LEN_W    = wsrt_pkg::LEN_W;
  localparam int CW_W     = $clog2(MAX_WINDOW + 1);
  localparam int PROD_W   = CW_W + SEGB_W;
  localparam logic [WIN_W-1:0] MAXW = WIN_W'(MAX_WINDOW);

  // configuration
  logic [SEGB_W-1:0]        seg_bytes_r;
  logic [wsrt_pkg::HDR_W-1:0] hdr_r;
  logic [SEQ_W-1:0]         flow_r;
  logic [WIN_W-1:0]         start_win_r;
  logic [WIN_W-1:0]         win_lim_r;
  logic [SEQ_W-1:0]         retx_r;
  logic                     prio_mode_r;

  // latched item
  logic [wsrt_pkg::KIND_W-1:0]     kind_r;
  logic [SEQ_W-1:0]                ack_r;
  logic [wsrt_pkg::SACK_CNT_W-1:0] sacks_r;

  // flow state
  logic [SEQ_W-1:0]    next_seq_r;
  logic [SEQ_W-1:0]    oldest_r;
  logic [CW_W-1:0]     cong_r;
  logic [SACKED_W-1:0] sacked_r;
  logic                armed_r;
  logic [SEQ_W-1:0]    left_r;
  logic                done_r;

  // per item work registers
  logic                new_r;
  logic                done_pend_r;
  logic [PROD_W-1:0]   prod_r;
  logic [SEQ_W-1:0]    prio_r;
  logic [SEQ_W:0]      limit_r;
  logic [CNT_W-1:0]    sent_r;
  logic                stage_v_r;
  logic [SEQ_W-1:0]    stage_seq_r;
  logic [LEN_W-1:0]    stage_len_r;

  // output register
  logic                out_valid_r;
  logic                out_kind_r;
  logic [SEQ_W-1:0]    out_seq_r;
  logic [LEN_W-1:0]    out_len_r;
  logic [SEQ_W-1:0]    out_prio_r;
  logic                out_last_r;

  logic [SEGB_W-1:0]   mss;
  logic [WIN_W-1:0]    start_cl;
  logic [WIN_W-1:0]    lim_cl;
  logic [CW_W:0]       cong_inc;
  logic [CW_W-1:0]     cong_nxt;
  logic [SACKED_W-1:0] sacked_nxt;
  logic                new_ack;
  logic [SEQ_W:0]      seq_sum;
  logic                cond;
  logic                over;
  logic [SEQ_W-1:0]    tail;
  logic [SEGB_W-1:0]   pay_len;
  logic [LEN_W:0]      len_full;
  logic [LEN_W-1:0]    seg_len_nxt;
  logic [SEQ_W-1:0]    seq_nxt;
  logic [SEQ_W:0]      used;
  logic [SEQ_W-1:0]    prio_nxt;
  logic [SEQ_W:0]      limit_nxt;
  logic                arm_ok;
  logic                out_free;
  logic                rearm_go;

  assign cfg_ready = 1'b1;

  assign mss      = (seg_bytes_r == '0) ? SEGB_W'(1) : seg_bytes_r;
  assign start_cl = (start_win_r < MAXW) ? start_win_r : MAXW;
  assign lim_cl   = (win_lim_r < MAXW) ? win_lim_r : MAXW;
  assign cong_inc = {1'b0, cong_r} + (CW_W+1)'(1);
  assign cong_nxt = (cong_inc > {1'b0, CW_W'(lim_cl)}) ? CW_W'(lim_cl) : cong_inc[CW_W-1:0];
  assign sacked_nxt = SACKED_W'(sacks_r) * SACKED_W'(mss);
  assign new_ack    = ack_r > oldest_r;
  assign arm_ok     = oldest_r < flow_r;

  // send test and segment shaping at the current send pointer
  assign seq_sum = {1'b0, next_seq_r} + (SEQ_W+1)'(mss);
  assign cond    = (sent_r < wsrt_pkg::SEG_CAP) && (seq_sum <= limit_r) && (next_seq_r < flow_r);
  assign over    = seq_sum > {1'b0, flow_r};
  assign tail    = flow_r - next_seq_r;
  assign pay_len = over ? tail[SEGB_W-1:0] : mss;
  assign len_full = (LEN_W+1)'(pay_len) + (LEN_W+1)'(hdr_r);
  assign seg_len_nxt = (len_full > (LEN_W+1)'(wsrt_pkg::LEN_MAX)) ? wsrt_pkg::LEN_MAX
                                                                  : len_full[LEN_W-1:0];
  assign seq_nxt = over ? flow_r : seq_sum[SEQ_W-1:0];

  // priority and window edge, fixed for the whole send run
  assign used      = {1'b0, oldest_r} + (SEQ_W+1)'(sacked_r);
  assign prio_nxt  = prio_mode_r ? SEQ_W'(1)
                   : (({1'b0, flow_r} > used) ? (flow_r - used[SEQ_W-1:0]) : '0);
  assign limit_nxt = {1'b0, oldest_r} + (SEQ_W+1)'(prod_r) + (SEQ_W+1)'(sacked_r);

  assign out_free = !out_valid_r || out_ready;
  assign rearm_go = (kind_r == wsrt_pkg::KIND_TICK) || (new_r && armed_r);

  assign stat.kind      = kind_r;
  assign stat.flow_done = done_r;
  assign stat.armed     = armed_r;
  assign stat.left_le1  = (left_r <= SEQ_W'(1));
  assign stat.new_ack   = new_ack;
  assign stat.cond      = cond;
  assign stat.stage_v   = stage_v_r;
  assign stat.done_pend = done_pend_r;
  assign stat.out_free  = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_bytes_r <= wsrt_pkg::RST_SEGMENT_BYTES;
      hdr_r       <= wsrt_pkg::RST_HEADER_BYTES;
      flow_r      <= wsrt_pkg::RST_FLOW_BYTES;
      start_win_r <= wsrt_pkg::RST_START_WINDOW;
      win_lim_r   <= wsrt_pkg::RST_WINDOW_LIMIT;
      retx_r      <= wsrt_pkg::RST_RETX_TICKS;
      prio_mode_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        wsrt_pkg::CFG_SEGMENT_BYTES: seg_bytes_r <= cfg_data[SEGB_W-1:0];
        wsrt_pkg::CFG_HEADER_BYTES:  hdr_r       <= cfg_data[wsrt_pkg::HDR_W-1:0];
        wsrt_pkg::CFG_FLOW_BYTES:    flow_r      <= cfg_data[SEQ_W-1:0];
        wsrt_pkg::CFG_START_WINDOW:  start_win_r <= cfg_data[WIN_W-1:0];
        wsrt_pkg::CFG_WINDOW_LIMIT:  win_lim_r   <= cfg_data[WIN_W-1:0];
        wsrt_pkg::CFG_RETX_TICKS:    retx_r      <= cfg_data[SEQ_W-1:0];
        wsrt_pkg::CFG_PRIORITY_MODE: prio_mode_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_seq_r  <= '0;
      oldest_r    <= '0;
      cong_r      <= CW_W'(wsrt_pkg::RST_START_WINDOW < MAXW ? wsrt_pkg::RST_START_WINDOW
                                                             : MAXW);
      sacked_r    <= '0;
      armed_r     <= 1'b0;
      left_r      <= '0;
      done_r      <= 1'b0;
      new_r       <= 1'b0;
      done_pend_r <= 1'b0;
      sent_r      <= '0;
      stage_v_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.latch) begin
        kind_r      <= in_kind;
        ack_r       <= in_ack_seq;
        sacks_r     <= in_sack_count;
        new_r       <= 1'b0;
        done_pend_r <= 1'b0;
      end
      if (cmd.clear) begin
        next_seq_r <= '0;
        oldest_r   <= '0;
        cong_r     <= CW_W'(start_cl);
        sacked_r   <= '0;
        armed_r    <= 1'b0;
        left_r     <= '0;
        done_r     <= 1'b0;
      end
      if (cmd.ack_upd) begin
        sacked_r    <= sacked_nxt;
        new_r       <= new_ack;
        done_pend_r <= (ack_r == flow_r);
        if (next_seq_r < ack_r) begin
          next_seq_r <= ack_r;
        end
        if (new_ack) begin
          oldest_r <= ack_r;
          cong_r   <= cong_nxt;
        end
      end
      if (cmd.timeout) begin
        armed_r    <= 1'b0;
        left_r     <= '0;
        next_seq_r <= oldest_r;
        cong_r     <= CW_W'(1);
      end
      if (cmd.tick_dec) begin
        left_r <= left_r - SEQ_W'(1);
      end
      if (cmd.setup1) begin
        prod_r <= PROD_W'(cong_r) * PROD_W'(mss);
        prio_r <= prio_nxt;
      end
      if (cmd.setup2) begin
        limit_r   <= limit_nxt;
        sent_r    <= '0;
        stage_v_r <= 1'b0;
      end
      if (cmd.gen) begin
        stage_seq_r <= next_seq_r;
        stage_len_r <= seg_len_nxt;
        stage_v_r   <= 1'b1;
        next_seq_r  <= seq_nxt;
        sent_r      <= sent_r + CNT_W'(1);
        if (!armed_r && arm_ok) begin
          armed_r <= 1'b1;
          left_r  <= retx_r;
        end
      end
      if (cmd.rearm && rearm_go) begin
        armed_r <= arm_ok;
        left_r  <= arm_ok ? retx_r : '0;
      end
      if (cmd.emit_seg) begin
        stage_v_r   <= 1'b0;
        out_valid_r <= 1'b1;
        out_kind_r  <= wsrt_pkg::RES_SEG;
        out_seq_r   <= stage_seq_r;
        out_len_r   <= stage_len_r;
        out_prio_r  <= prio_r;
        out_last_r  <= !cond && !done_pend_r;
      end else if (cmd.emit_done) begin
        done_r      <= 1'b1;
        out_valid_r <= 1'b1;
        out_kind_r  <= wsrt_pkg::RES_DONE;
        out_seq_r   <= '0;
        out_len_r   <= '0;
        out_prio_r  <= '0;
        out_last_r  <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = out_kind_r;
  assign out_seq   = out_seq_r;
  assign out_len   = out_len_r;
  assign out_prio  = out_prio_r;
  assign out_last  = out_last_r;

  `WSRT_ASSERT(a_emit_free, !(cmd.emit_seg || cmd.emit_done) || out_free, "result loaded into busy output")
  `WSRT_ASSERT(a_gen_data, !cmd.gen || (next_seq_r < flow_r && sent_r < wsrt_pkg::SEG_CAP), "segment generated past flow end or cap")
  `WSRT_ASSERT_NEXT(a_timeout_rewind, cmd.timeout, next_seq_r == oldest_r && cong_r == CW_W'(1) && !armed_r, "timeout did not rewind")
  `WSRT_ASSERT_NEXT(a_gen_stage, cmd.gen, stage_v_r && stage_len_r != '0, "generated segment not staged")

endmodule

/* dv/wsrt_flow_checker.sv */
`timescale 1ns / 100ps
// transfer monitor and result predictor for the window sender with retransmit timer
// depends on wsrt_pkg; watches the in_, out_ and cfg_ channels of the block
module wsrt_flow_checker #(
  parameter int MAX_WINDOW = wsrt_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [39:0]                     in_tdata,   // ack_seq [31:0], sack_count [37:32]
  input  logic [1:0]                      in_tuser,   // kind [1:0]
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  input  logic [79:0]                     out_tdata,  // segment_seq [31:0],
                                                      // segment_len [45:32],
                                                      // priority_res [77:46]
  input  logic [0:0]                      out_tuser,  // result_kind [0]
  input  logic                            out_tlast,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [wsrt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wsrt_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              fail_count,
  output int                              pending
);
  import wsrt_pkg::*;

  typedef struct packed {
    logic             kind;
    logic [SEQ_W-1:0] seq;
    logic [LEN_W-1:0] len;
    logic [SEQ_W-1:0] prio;
    logic             last;
  } seg_result_t;

  seg_result_t expected_segs[$];
  seg_result_t item_segs[$];
  int          mismatches = 0;

  // register copies
  logic [SEGB_W-1:0] r_seg_bytes;
  logic [HDR_W-1:0]  r_hdr_bytes;
  logic [SEQ_W-1:0]  r_flow;
  logic [WIN_W-1:0]  r_start_win;
  logic [WIN_W-1:0]  r_win_limit;
  logic [SEQ_W-1:0]  r_retx;
  logic              r_prio_mode;

  // flow state, kept wide so sums never wrap
  longint unsigned snd_nxt, snd_una, cwnd, sack_bytes, rto_left;
  bit              rto_on, flow_fin;

  assign fail_count = mismatches;

  function automatic longint unsigned seg_size();
    return (r_seg_bytes == 0) ? 64'd1 : 64'(r_seg_bytes);
  endfunction

  task automatic clear_flow();
    snd_nxt    = 0;
    snd_una    = 0;
    cwnd       = (r_start_win < MAX_WINDOW) ? 64'(r_start_win) : 64'(MAX_WINDOW);
    sack_bytes = 0;
    rto_on     = 1'b0;
    rto_left   = 0;
    flow_fin   = 1'b0;
  endtask

  task automatic push_result(logic k, longint unsigned seq, longint unsigned len,
                             longint unsigned prio);
    seg_result_t r;
    r.kind = k;
    r.seq  = SEQ_W'(seq);
    r.len  = (len > 64'(LEN_MAX)) ? LEN_MAX : LEN_W'(len);
    r.prio = SEQ_W'(prio);
    r.last = 1'b0;
    item_segs = {item_segs, r};
  endtask

  task automatic restart_timer();
    if (snd_una < r_flow) begin
      rto_on   = 1'b1;
      rto_left = r_retx;
    end
  endtask

  // emit segments while the window and the per-item cap allow
  task automatic send_window();
    longint unsigned mss, seq, wnd, seg_len, prio, used;
    int              sent;
    mss  = seg_size();
    seq  = snd_nxt;
    wnd  = cwnd * mss + sack_bytes;
    sent = 0;
    while (sent < int'(SEG_CAP) && seq + mss <= snd_una + wnd && seq < r_flow) begin
      seg_len = (seq + mss > r_flow) ? r_flow - seq : mss;
      if (r_prio_mode) begin
        prio = 1;
      end else begin
        used = snd_una + sack_bytes;
        prio = (r_flow > used) ? r_flow - used : 0;
      end
      push_result(RES_SEG, seq, seg_len + r_hdr_bytes, prio);
      sent++;
      seq     = (seq + mss < r_flow) ? seq + mss : 64'(r_flow);
      snd_nxt = seq;
      if (!rto_on) restart_timer();
    end
  endtask

  task automatic sender_step(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] ack_v,
                             logic [SACK_CNT_W-1:0] sacks);
    longint unsigned lim;
    item_segs.delete();
    case (kind)
      KIND_START: begin
        clear_flow();
        send_window();
      end
      KIND_ACK: begin
        if (!flow_fin) begin
          sack_bytes = 64'(sacks) * seg_size();
          if (snd_nxt < ack_v) snd_nxt = ack_v;
          if (ack_v > snd_una) begin
            lim     = (r_win_limit < MAX_WINDOW) ? 64'(r_win_limit) : 64'(MAX_WINDOW);
            snd_una = ack_v;
            cwnd    = (cwnd + 1 > lim) ? lim : cwnd + 1;
            send_window();
            if (rto_on) begin
              rto_on   = 1'b0;
              rto_left = 0;
              restart_timer();
            end
          end
          if (ack_v == r_flow) begin
            flow_fin = 1'b1;
            push_result(RES_DONE, 0, 0, 0);
          end
        end
      end
      KIND_TICK: begin
        if (rto_on) begin
          if (rto_left <= 1) begin
            rto_on   = 1'b0;
            rto_left = 0;
            snd_nxt  = snd_una;
            cwnd     = 1;
            send_window();
            restart_timer();
          end else begin
            rto_left = rto_left - 1;
          end
        end
      end
      default: ;
    endcase
    if (item_segs.size() > 0) begin
      item_segs[item_segs.size() - 1].last = 1'b1;
    end
    expected_segs = {expected_segs, item_segs};
  endtask

  always @(posedge clk) begin
    seg_result_t got, want;
    if (!rst_n) begin
      r_seg_bytes = RST_SEGMENT_BYTES;
      r_hdr_bytes = RST_HEADER_BYTES;
      r_flow      = RST_FLOW_BYTES;
      r_start_win = RST_START_WINDOW;
      r_win_limit = RST_WINDOW_LIMIT;
      r_retx      = RST_RETX_TICKS;
      r_prio_mode = 1'b0;
      clear_flow();
      expected_segs.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_SEGMENT_BYTES: r_seg_bytes = cfg_data[SEGB_W-1:0];
          CFG_HEADER_BYTES:  r_hdr_bytes = cfg_data[HDR_W-1:0];
          CFG_FLOW_BYTES:    r_flow      = cfg_data[SEQ_W-1:0];
          CFG_START_WINDOW:  r_start_win = cfg_data[WIN_W-1:0];
          CFG_WINDOW_LIMIT:  r_win_limit = cfg_data[WIN_W-1:0];
          CFG_RETX_TICKS:    r_retx      = cfg_data[SEQ_W-1:0];
          CFG_PRIORITY_MODE: r_prio_mode = cfg_data[0];
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) begin
        got.kind = out_tuser[0];
        got.seq  = out_tdata[31:0];
        got.len  = out_tdata[45:32];
        got.prio = out_tdata[77:46];
        got.last = out_tlast;
        if (expected_segs.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, expected none, got kind %0d seq %0h", $time,
                   got.kind, got.seq, " len %0d prio %0h last %0d",
                   got.len, got.prio, got.last);
        end else begin
          want = expected_segs.pop_front();
          if (got !== want) begin
            mismatches++;
            $display("%0t: expected kind %0d seq %0h len %0d prio %0h last %0d", $time,
                     want.kind, want.seq, want.len, want.prio, want.last);
            $display("%0t: got      kind %0d seq %0h len %0d prio %0h last %0d", $time,
                     got.kind, got.seq, got.len, got.prio, got.last);
          end
        end
      end
      if (in_tvalid && in_tready) sender_step(in_tuser, in_tdata[31:0], in_tdata[37:32]);
    end
    pending <= expected_segs.size();
  end

endmodule

/* dv/tb_window_sender_with_retx_timer_core.sv */
`timescale 1ns / 100ps
// stimulus and verdict for window_sender_with_retx_timer_core
// depends on wsrt_pkg, the block and wsrt_flow_checker, which predicts and compares
module tb_window_sender_with_retx_timer_core;
  import wsrt_pkg::*;

  localparam int STALL_LIMIT    = 4000;  // cycles with no transfer at all before giving up
  localparam int SQUEEZE_CYCLES = 400;   // long receiver hold-off
  localparam int DRAIN_CYCLES   = 40;    // covers an item that sends nothing still in flight
  localparam int RAND_PHASES    = 6;
  localparam int ITEMS_PER_PHASE = 60;

  // kind code the block ignores
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [39:0]           in_tdata;   // ack_seq [31:0], sack_count [37:32], zero fill
  logic [1:0]            in_tuser;   // kind [1:0]
  logic                  out_tvalid;
  logic                  out_tready;
  logic [79:0]           out_tdata;  // segment_seq [31:0], segment_len [45:32],
                                     // priority_res [77:46]
  logic [0:0]            out_tuser;  // result_kind [0]
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int fail_count;
  int pending;

  // stimulus-side view of the current flow, used to shape plausible acks
  longint unsigned mss_cur, flow_cur, ack_guess;

  // idling control shared by both sides
  bit calm = 1'b0;
  int squeeze_req = 0;
  int squeeze_seen = 0;
  int hold_left = 0;
  int quiet = 0;

  window_sender_with_retx_timer_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  wsrt_flow_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random back-pressure, calm stretches, and one long hold-off on request
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left  <= hold_left - 1;
    end else if (squeeze_req != squeeze_seen) begin
      squeeze_seen <= squeeze_req;
      hold_left    <= SQUEEZE_CYCLES;
      out_tready   <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(99) >= 29);
    end
  end

  // watchdog: ends the run when no channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
    end
    if (quiet >= STALL_LIMIT) begin
      $display("window_sender_with_retx_timer_core: mismatch");
      $finish;
    end
  end

  // one input transfer; valid stays high on return, so back-to-back items in calm stretches never dip
  task automatic put_item(logic [KIND_W-1:0] kind, logic [SEQ_W-1:0] ack_v,
                          logic [SACK_CNT_W-1:0] sacks);
    if (!calm) begin
      while ($urandom_range(99) < 29) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {2'b00, sacks, ack_v};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // full register set, only called with the block idle
  task automatic set_regs(logic [SEGB_W-1:0] mss, logic [HDR_W-1:0] hdr,
                          logic [SEQ_W-1:0] flow, logic [WIN_W-1:0] iw,
                          logic [WIN_W-1:0] wmax, logic [SEQ_W-1:0] retx, logic prio);
    write_reg(CFG_SEGMENT_BYTES, 32'(mss));
    write_reg(CFG_HEADER_BYTES, 32'(hdr));
    write_reg(CFG_FLOW_BYTES, flow);
    write_reg(CFG_START_WINDOW, 32'(iw));
    write_reg(CFG_WINDOW_LIMIT, 32'(wmax));
    write_reg(CFG_RETX_TICKS, retx);
    write_reg(CFG_PRIORITY_MODE, 32'(prio));
    cfg_valid <= 1'b0;
    mss_cur   = (mss == 0) ? 1 : mss;
    flow_cur  = flow;
    ack_guess = 0;
  endtask

  // stop offering, wait for every expected result, then let any silent item finish
  task automatic settle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic random_regs();
    longint unsigned mss, flow, retx;
    mss  = ($urandom_range(7) == 0) ? 64'd9000 : 64'($urandom_range(1, 1500));
    flow = mss * $urandom_range(0, 24) + $urandom_range(0, 32'(mss - 1));
    retx = ($urandom_range(7) == 0) ? 64'hFFFF_FFFF : 64'($urandom_range(1, 6));
    set_regs(SEGB_W'(mss), HDR_W'($urandom_range(0, 255)), SEQ_W'(flow),
             WIN_W'($urandom_range(1, 32)), WIN_W'($urandom_range(1, 32)),
             SEQ_W'(retx), 1'($urandom_range(1)));
  endtask

  // mostly a live flow: starts, advancing acks and ticks; the rest is noise
  task automatic rand_item();
    int              r;
    longint unsigned step;
    r = $urandom_range(99);
    if (r < 8 || (ack_guess >= flow_cur && $urandom_range(3) == 0)) begin
      ack_guess = 0;
      put_item(KIND_START, $urandom, SACK_CNT_W'($urandom_range(0, 63)));
    end else if (r < 50) begin
      step      = mss_cur * $urandom_range(0, 3);
      ack_guess = (ack_guess + step > flow_cur) ? flow_cur : ack_guess + step;
      put_item(KIND_ACK, SEQ_W'(ack_guess), SACK_CNT_W'($urandom_range(0, 4)));
    end else if (r < 85) begin
      put_item(KIND_TICK, $urandom, SACK_CNT_W'($urandom_range(0, 63)));
    end else if (r < 90) begin
      // whole flow acknowledged
      ack_guess = flow_cur;
      put_item(KIND_ACK, SEQ_W'(flow_cur), SACK_CNT_W'($urandom_range(0, 32)));
    end else begin
      case ($urandom_range(2))
        0: put_item(KIND_UNKNOWN, $urandom, SACK_CNT_W'($urandom_range(0, 63)));
        1: put_item(KIND_ACK, $urandom, SACK_CNT_W'($urandom_range(0, 63)));  // wild ack
        default: put_item(KIND_ACK, $urandom_range(0, 32'(ack_guess)),
                          SACK_CNT_W'($urandom_range(0, 32)));  // stale or duplicate ack
      endcase
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    mss_cur    = RST_SEGMENT_BYTES;
    flow_cur   = RST_FLOW_BYTES;
    ack_guess  = 0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings: one full segment, full ack, ack after done, unknown kind
    put_item(KIND_START, 32'd0, 6'd0);
    put_item(KIND_TICK, 32'd0, 6'd0);
    put_item(KIND_ACK, 32'd1460, 6'd0);
    put_item(KIND_ACK, 32'd1460, 6'd1);
    put_item(KIND_UNKNOWN, 32'hFFFF_FFFF, 6'd63);
    put_item(KIND_START, 32'd0, 6'd0);
    settle();

    // zero segment size acts as one byte, timeout of zero fires on the first tick
    set_regs(14'd0, 8'd255, 32'd5, 6'd1, 6'd32, 32'd0, 1'b0);
    put_item(KIND_START, 32'd0, 6'd0);
    put_item(KIND_TICK, 32'd0, 6'd0);
    put_item(KIND_ACK, 32'd2, 6'd3);
    put_item(KIND_ACK, 32'd5, 6'd32);
    settle();

    // largest segments saturate the length, sacks push past the per-item cap
    set_regs(14'h3FFF, 8'd255, 32'hFFFF_FFFF, 6'd32, 6'd32, 32'd2, 1'b1);
    put_item(KIND_START, 32'd0, 6'd0);
    put_item(KIND_ACK, 32'd16383, 6'd63);
    put_item(KIND_TICK, 32'd0, 6'd0);
    put_item(KIND_TICK, 32'd0, 6'd0);
    put_item(KIND_ACK, 32'hFFFF_FFFF, 6'd0);
    settle();

    // empty flow: nothing to send, ack of zero completes it
    set_regs(14'd9000, 8'd0, 32'd0, 6'd1, 6'd1, 32'd1, 1'b0);
    put_item(KIND_START, 32'd0, 6'd0);
    put_item(KIND_TICK, 32'd0, 6'd0);
    put_item(KIND_ACK, 32'd0, 6'd0);
    settle();

    // window limit below start window, short last segment, duplicate ack
    set_regs(14'd100, 8'd10, 32'd1050, 6'd3, 6'd1, 32'd1, 1'b0);
    put_item(KIND_START, 32'd0, 6'd0);
    put_item(KIND_ACK, 32'd300, 6'd2);
    put_item(KIND_ACK, 32'd300, 6'd0);
    put_item(KIND_TICK, 32'd0, 6'd0);
    put_item(KIND_ACK, 32'd1050, 6'd0);
    settle();

    // random phases, each with fresh settings
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      random_regs();
      calm <= (ph == 3);
      if (ph == 1) squeeze_req <= squeeze_req + 1;  // receiver stalls while items keep coming
      put_item(KIND_START, 32'd0, 6'd0);
      for (int n = 1; n < ITEMS_PER_PHASE; n++) rand_item();
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("window_sender_with_retx_timer_core: match");
    end else begin
      $display("window_sender_with_retx_timer_core: mismatch");
    end
    $finish;
  end

endmodule
